// ----- design/kli_pkg.sv -----
// Package for the keyframe linear interpolator.
// Holds command and status codes, the controller state type and the command/status structs.
package kli_pkg;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_MAINTAIN = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FEW       = 2'd1,
    ST_TOO_OLD   = 2'd2,
    ST_NOT_BETW  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_NEW,
    S_AGE,
    S_ADD,
    S_Q_START,
    S_Q_RD,
    S_Q_STEP,
    S_Q_PAIR,
    S_Q_DIV,
    S_Q_FIN,
    S_OUT
  } state_t;

  localparam int MS_PER_SEC  = 1000;
  localparam int MS_MAX      = 999;
  localparam int T_MAX       = 63999;
  localparam int T_WRAP      = 64000;
  localparam int DIV_STEPS   = 48;

  typedef struct packed {
    logic load;       // latch input item
    logic age_eval;   // apply age check
    logic add_eval;   // apply add
    logic clear;      // empty ring
    logic q_init;     // start query walk
    logic q_rd;       // read previous frame
    logic q_step;     // evaluate one walk step
    logic q_pair;     // set up division
    logic div_step;   // one multiply or division step
    logic q_fin;      // form result
  } ctl_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    q_fail;     // query ended early with status
    logic    q_found;    // bracketing pair found
    logic    q_more;     // more frames to walk
    logic    q_trivial;  // endpoint, no division
    logic    div_done;
  } sts_t;

endpackage

// ----- design/kli_if.sv -----
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload width is a parameter.
interface kli_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/kli_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- design/kli_ctrl.sv -----
// Controller state machine of the keyframe interpolator.
// Uses kli_pkg for states and command/status structs.
module kli_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_fire,
  input  kli_pkg::sts_t   sts,
  output kli_pkg::ctl_t   ctl,
  output logic            busy,
  output logic            out_pend
);
  kli_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kli_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kli_pkg::S_IDLE:    if (in_fire) state_nxt = kli_pkg::S_RD_NEW;
      kli_pkg::S_RD_NEW: begin
        case (sts.cmd)
          kli_pkg::CMD_QUERY: state_nxt = kli_pkg::S_Q_START;
          kli_pkg::CMD_CLEAR: state_nxt = kli_pkg::S_IDLE;
          default:            state_nxt = kli_pkg::S_AGE;
        endcase
      end
      kli_pkg::S_AGE:
        state_nxt = (sts.cmd == kli_pkg::CMD_ADD) ? kli_pkg::S_ADD : kli_pkg::S_IDLE;
      kli_pkg::S_ADD:     state_nxt = kli_pkg::S_IDLE;
      kli_pkg::S_Q_START:
        state_nxt = sts.q_fail ? kli_pkg::S_OUT : kli_pkg::S_Q_RD;
      kli_pkg::S_Q_RD:    state_nxt = kli_pkg::S_Q_STEP;
      kli_pkg::S_Q_STEP: begin
        if (sts.q_found) state_nxt = kli_pkg::S_Q_PAIR;
        else if (sts.q_more) state_nxt = kli_pkg::S_Q_RD;
        else state_nxt = kli_pkg::S_OUT;
      end
      kli_pkg::S_Q_PAIR:
        state_nxt = sts.q_trivial ? kli_pkg::S_OUT : kli_pkg::S_Q_DIV;
      kli_pkg::S_Q_DIV:   if (sts.div_done) state_nxt = kli_pkg::S_Q_FIN;
      kli_pkg::S_Q_FIN:   state_nxt = kli_pkg::S_OUT;
      kli_pkg::S_OUT:     if (out_fire) state_nxt = kli_pkg::S_IDLE;
      default:            state_nxt = kli_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    busy = (state_r != kli_pkg::S_IDLE);
    out_pend = (state_r == kli_pkg::S_OUT);
    case (state_r)
      kli_pkg::S_IDLE:    ctl.load = in_fire;
      kli_pkg::S_RD_NEW:  ctl.clear = (sts.cmd == kli_pkg::CMD_CLEAR);
      kli_pkg::S_AGE:     ctl.age_eval = 1'b1;
      kli_pkg::S_ADD:     ctl.add_eval = 1'b1;
      kli_pkg::S_Q_START: ctl.q_init = 1'b1;
      kli_pkg::S_Q_RD:    ctl.q_rd = 1'b1;
      kli_pkg::S_Q_STEP:  ctl.q_step = 1'b1;
      kli_pkg::S_Q_PAIR:  ctl.q_pair = 1'b1;
      kli_pkg::S_Q_DIV:   ctl.div_step = 1'b1;
      kli_pkg::S_Q_FIN:   ctl.q_fin = 1'b1;
      default:            ctl = '0;
    endcase
  end
endmodule

// ----- design/kli_dp.sv -----
// Datapath of the keyframe interpolator: ring pointers, frame RAMs, walk and divider.
// Uses kli_pkg and kli_ram.
module kli_dp #(
  parameter int FRAMES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kli_pkg::ctl_t        ctl,
  output kli_pkg::sts_t        sts,
  input  logic [1:0]           in_cmd,
  input  logic [15:0]          in_time,
  input  logic signed [31:0]   in_val,
  input  logic                 in_fin,
  input  logic [9:0]           max_age,
  output logic signed [31:0]   res_value,
  output logic                 res_valid,
  output logic [1:0]           res_status
);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  // input latch
  kli_pkg::cmd_t      cmd_r;
  logic [15:0]        t_r;
  logic signed [31:0] v_r;
  logic               fin_r;
  logic [9:0]         ms_r;

  logic [IW-1:0] start_r;
  logic [CW-1:0] count_r;

  // ring index helpers
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, a} + {1'b0, b};
    if (s >= (CW+1)'(FRAMES)) s = s - (CW+1)'(FRAMES);
    return s[IW-1:0];
  endfunction
  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] a);
    return (a == '0) ? IW'(FRAMES - 1) : a - 1'b1;
  endfunction

  logic [IW-1:0] newest;
  assign newest = wrap_add(start_r, count_r - 1'b1);

  // RAM access
  logic          we;
  logic [IW-1:0] addr, wslot, cur_r, bi_r;
  logic [9:0]    rt;
  logic [31:0]   rv;

  kli_ram #(.WIDTH(10), .DEPTH(FRAMES)) u_time (
    .clk(clk), .we(we), .addr(addr), .wdata(ms_r), .rdata(rt));
  kli_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_val (
    .clk(clk), .we(we), .addr(addr), .wdata(v_r), .rdata(rv));

  // add decision
  logic add_ok;
  logic age_kill;
  logic [10:0] age_diff;
  always_comb begin
    age_diff = {1'b0, ms_r} + 11'd1000 - {1'b0, rt};
    if (age_diff >= 11'(kli_pkg::MS_PER_SEC)) age_diff = age_diff - 11'd1000;
    age_kill = (count_r != '0) && (age_diff[9:0] >= max_age);
  end
  assign add_ok = ctl.add_eval && fin_r && ((count_r == '0) || (rt != ms_r));
  always_comb begin
    if (count_r == '0) wslot = start_r;
    else if (count_r >= CW'(FRAMES)) wslot = start_r;
    else wslot = wrap_add(start_r, count_r);
  end
  assign we = add_ok;

  // query state
  logic [16:0] tt_r;       // to_target, 1/64 ms
  logic [9:0]  ti_t_r;     // time at current (newer) frame
  logic signed [31:0] ti_v_r;
  logic [CW-1:0] left_r;
  logic signed [31:0] bv_r;

  // keep the base frame on the read port through the step so the pair setup sees it
  always_comb begin
    if (ctl.q_rd) addr = wrap_dec(cur_r);
    else if (ctl.q_step) addr = bi_r;
    else if (we) addr = wslot;
    else addr = newest;
  end

  logic [15:0] tsat;
  assign tsat = (t_r > 16'(kli_pkg::T_MAX)) ? 16'(kli_pkg::T_MAX) : t_r;

  logic [16:0] tt0;
  always_comb begin
    tt0 = {1'b0, rt, 6'd0} - {1'b0, tsat};
    if (tt0[16]) tt0 = tt0 + 17'd64000;
  end

  logic [9:0] gap;
  always_comb begin
    gap = (rt <= ti_t_r) ? ti_t_r - rt : ti_t_r + 10'd1000 - rt;
  end

  // divider: |diff| (33b) * since (16b) / span (17b)
  logic [48:0] num_r;
  logic [16:0] den_r;
  logic [17:0] rem_r;
  logic [48:0] quo_r;
  logic [5:0]  dcnt_r;
  logic        neg_r;
  logic [15:0] since_r;
  logic [32:0] adiff_r;
  logic        mulph_r;

  logic [16:0] span_c;
  logic [16:0] since_c;
  logic signed [32:0] diff_c;
  always_comb begin
    span_c = (ti_t_r > rt) ? {1'b0, ti_t_r - rt, 6'd0}
                           : {1'b0, ti_t_r + 10'd1000 - rt, 6'd0};
    since_c = {1'b0, tsat} - {1'b0, rt, 6'd0};
    if (since_c[16]) since_c = since_c + 17'd64000;
    diff_c = {ti_v_r[31], ti_v_r} - {rv[31], rv};
  end

  logic [17:0] rem_sh;
  assign rem_sh = {rem_r[16:0], num_r[48]};

  logic signed [33:0] r_c;
  logic signed [31:0] lo, hi;
  always_comb begin
    r_c = neg_r ? {bv_r[31], bv_r[31], bv_r} - {1'b0, quo_r[32:0]}
                : {bv_r[31], bv_r[31], bv_r} + {1'b0, quo_r[32:0]};
    lo = (bv_r < ti_v_r) ? bv_r : ti_v_r;
    hi = (bv_r < ti_v_r) ? ti_v_r : bv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= '0;
    end else begin
      if (ctl.clear) count_r <= '0;
      if (ctl.age_eval && age_kill) count_r <= '0;
      if (add_ok) begin
        if (count_r == '0) count_r <= CW'(1);
        else if (count_r >= CW'(FRAMES)) begin
          start_r <= wrap_add(start_r, CW'(1));
        end else count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= kli_pkg::cmd_t'(in_cmd);
      t_r   <= in_time;
      v_r   <= in_val;
      fin_r <= in_fin;
      ms_r  <= (in_time[15:6] > 10'(kli_pkg::MS_MAX)) ? 10'(kli_pkg::MS_MAX) : in_time[15:6];
    end
    // after age kill the add sees an empty ring; rt still valid
    if (ctl.q_init) begin
      cur_r  <= newest;
      ti_t_r <= rt;
      ti_v_r <= rv;
      tt_r   <= tt0;
      left_r <= count_r - 1'b1;
      if (count_r < CW'(2)) begin
        res_status <= kli_pkg::ST_FEW;
        res_valid <= 1'b0;
        res_value <= '0;
      end else if (tt0 > {1'b0, max_age, 6'd0}) begin
        res_status <= kli_pkg::ST_TOO_OLD;
        res_valid <= 1'b0;
        res_value <= '0;
      end
    end
    if (ctl.q_rd) bi_r <= wrap_dec(cur_r);
    if (ctl.q_step) begin
      left_r <= left_r - 1'b1;
      if (tt_r > {1'b0, gap, 6'd0}) begin
        tt_r <= tt_r - {1'b0, gap, 6'd0};
        cur_r <= bi_r;
        ti_t_r <= rt;
        ti_v_r <= rv;
        if (left_r == CW'(1)) begin
          res_status <= kli_pkg::ST_NOT_BETW;
          res_valid <= 1'b0;
          res_value <= '0;
        end
      end
    end
    if (ctl.q_pair) begin
      bv_r <= rv;
      res_status <= kli_pkg::ST_OK;
      res_valid <= 1'b1;
      if (since_c == '0) res_value <= rv;
      else if (since_c >= span_c) res_value <= ti_v_r;
      den_r   <= span_c;
      since_r <= since_c[15:0];
      neg_r   <= diff_c[32];
      adiff_r <= diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
      mulph_r <= 1'b1;
      dcnt_r  <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
    end
    if (ctl.div_step) begin
      if (mulph_r) begin
        num_r <= 49'(adiff_r) * 49'(since_r);
        mulph_r <= 1'b0;
      end else begin
        num_r <= {num_r[47:0], 1'b0};
        dcnt_r <= dcnt_r + 1'b1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[47:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[47:0], 1'b0};
        end
      end
    end
    if (ctl.q_fin) begin
      if (r_c < 34'(lo)) res_value <= lo;
      else if (r_c > 34'(hi)) res_value <= hi;
      else res_value <= r_c[31:0];
    end
  end

  logic trivial;
  assign trivial = (since_c == '0) || (since_c >= span_c);

  always_comb begin
    sts.cmd       = cmd_r;
    sts.q_fail    = (count_r < CW'(2)) || (tt0 > {1'b0, max_age, 6'd0});
    sts.q_found   = (tt_r <= {1'b0, gap, 6'd0});
    sts.q_more    = (left_r > CW'(1));
    sts.q_trivial = trivial;
    sts.div_done  = !mulph_r && (dcnt_r == 6'(kli_pkg::DIV_STEPS));
  end
endmodule

// ----- design/keyframe_linear_interpolator_core.sv -----
// Keyframe linear interpolator: a ring of FRAMES timestamped Q16.16 keyframes with add,
// age maintenance, clear and interpolating query. One item is worked at a time. A query
// starts at the newest frame and walks back frame by frame, then sets up the pair, runs
// the multiply and the restoring divider, clamps and offers the result; endpoints skip
// the divider. The result register holds until transferred.
// Depends on kli_pkg, kli_if, kli_ram, kli_ctrl and kli_dp.
module keyframe_linear_interpolator_core #(
  parameter int FRAMES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  kli_if.sink        in_ch,
  kli_if.source      out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);
  logic [9:0] max_age_r;
  always_ff @(posedge clk) begin
    if (!rst_n) max_age_r <= 10'd200;
    else if (cfg_we) max_age_r <= cfg_wdata;
  end

  kli_pkg::ctl_t ctl;
  kli_pkg::sts_t sts;
  logic busy, out_pend, in_fire, out_fire;

  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && !busy;
  assign out_ch.valid = out_pend;
  assign out_fire     = out_pend && out_ch.ready;

  logic signed [31:0] rv;
  logic rvld;
  logic [1:0] rst_s;
  assign out_ch.data = {rv, rvld, rst_s};

  kli_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .ctl(ctl), .busy(busy), .out_pend(out_pend));

  kli_dp #(.FRAMES(FRAMES)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_ch.data[50:49]), .in_time(in_ch.data[48:33]),
    .in_val(in_ch.data[32:1]), .in_fin(in_ch.data[0]),
    .max_age(max_age_r), .res_value(rv), .res_valid(rvld), .res_status(rst_s));
endmodule

// ----- design/kli_checker.sv -----
// Port-level checker for the keyframe interpolator, bound to the top level.
// Depends on kli_pkg for status codes.
module kli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [34:0] out_data
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data[2] |-> out_data[34:3] == 32'd0)
    else $error("invalid result carries value");
  a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data[2] == (out_data[1:0] == kli_pkg::ST_OK)))
    else $error("valid flag disagrees with status");
endmodule

bind keyframe_linear_interpolator_core kli_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
